FILE: rtl/core/tgc_pkg.sv
`default_nettype none
// ============================================================================
// Touch gesture classifier package
// Shared widths, codes and transaction types for the gesture classifier core.
// ============================================================================
package tgc_pkg;

    localparam int TIME_BITS  = 32;
    localparam int COORD_BITS = 16;
    localparam int CFG_BITS   = 32;

    // Register indexes on the configuration port.
    localparam logic CFG_MAX_GESTURE_TIME = 1'b0;
    localparam logic CFG_LONG_PRESS_TIME  = 1'b1;

    localparam logic [CFG_BITS-1:0] MAX_GESTURE_TIME_RST = CFG_BITS'(1000);
    localparam logic [CFG_BITS-1:0] LONG_PRESS_TIME_RST  = CFG_BITS'(500);

    // Slot valid bit positions.
    localparam int SV_START   = 0;
    localparam int SV_HOLD    = 1;
    localparam int SV_RELEASE = 2;

    // Trigger flag bit positions.
    localparam int TF_DOWN = 0;
    localparam int TF_MOVE = 1;
    localparam int TF_UP   = 2;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2,
        EV_UP   = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        G_NEITHER = 2'd0,
        G_MOVETO  = 2'd1,
        G_CLICK   = 2'd2,
        G_LPUSH   = 2'd3
    } t_gesture;

    typedef struct packed {
        t_event_kind           event_kind;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]  stamp;
    } t_in_item;

    typedef struct packed {
        t_gesture              gesture;
        logic                  overflow;
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [COORD_BITS-1:0] final_x;
        logic [COORD_BITS-1:0] final_y;
        logic [TIME_BITS-1:0]  origin_stamp;
        logic [TIME_BITS-1:0]  final_stamp;
    } t_out_item;

    // Gesture tracking state carried from one event to the next.
    typedef struct packed {
        logic [2:0]            slot_valid;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] hold_x;
        logic [COORD_BITS-1:0] hold_y;
        logic                  hold_is_down;
        logic [COORD_BITS-1:0] rel_x;
        logic [COORD_BITS-1:0] rel_y;
        logic [TIME_BITS-1:0]  start_stamp;
        logic [TIME_BITS-1:0]  hold_stamp;
        logic [TIME_BITS-1:0]  rel_stamp;
        logic [2:0]            trig;
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/tgc_step.sv
`default_nettype none
// ============================================================================
// Gesture step logic
// Combinational update of the tracking state and the report for one event.
// ============================================================================
module tgc_step
    import tgc_pkg::*;
(
    input  wire t_state                i_state,
    input  wire t_out_item             i_rpt,
    input  wire t_in_item              i_item,
    input  wire logic [CFG_BITS-1:0]   i_max_time,
    input  wire logic [CFG_BITS-1:0]   i_long_time,
    output t_state                     o_state,
    output t_out_item                  o_rpt
);

    logic [TIME_BITS-1:0] dt;
    logic                 in_window;
    logic                 dn;
    logic                 mv;
    logic                 up;
    logic                 classify;

    assign dt        = i_item.stamp - i_state.start_stamp;
    assign in_window = {{(64-TIME_BITS){1'b0}}, dt} < {32'd0, i_max_time};

    always_comb begin
        o_state = i_state;
        o_rpt   = i_rpt;

        // Slot filling.
        if (!i_state.slot_valid[SV_START]) begin
            if (i_item.event_kind == EV_DOWN) begin
                o_state.start_x               = i_item.pos_x;
                o_state.start_y               = i_item.pos_y;
                o_state.start_stamp           = i_item.stamp;
                o_state.slot_valid[SV_START]  = 1'b1;
            end
        end else if (in_window) begin
            unique case (i_item.event_kind)
                EV_DOWN: begin
                    if (({{(64-TIME_BITS){1'b0}}, dt} >= {32'd0, i_long_time})
                        && (dt != '0)) begin
                        o_state.hold_x               = i_item.pos_x;
                        o_state.hold_y               = i_item.pos_y;
                        o_state.hold_stamp           = i_item.stamp;
                        o_state.hold_is_down         = 1'b1;
                        o_state.slot_valid[SV_HOLD]  = 1'b1;
                    end
                end
                EV_MOVE: begin
                    o_state.hold_x               = i_item.pos_x;
                    o_state.hold_y               = i_item.pos_y;
                    o_state.hold_stamp           = i_item.stamp;
                    o_state.hold_is_down         = 1'b0;
                    o_state.slot_valid[SV_HOLD]  = 1'b1;
                end
                EV_UP: begin
                    o_state.rel_x                   = i_item.pos_x;
                    o_state.rel_y                   = i_item.pos_y;
                    o_state.rel_stamp               = i_item.stamp;
                    o_state.slot_valid[SV_RELEASE]  = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            // Window expired: drop the gesture and every trigger.
            o_rpt.gesture      = G_NEITHER;
            o_rpt.overflow     = 1'b0;
            o_state.trig       = '0;
            o_state.slot_valid = '0;
        end

        // Triggers.
        if (o_state.slot_valid[SV_HOLD]) begin
            if (o_state.hold_is_down) begin
                o_state.trig[TF_DOWN] = 1'b1;
            end else begin
                o_state.trig[TF_MOVE] = 1'b1;
            end
        end
        if (o_state.slot_valid[SV_RELEASE]) begin
            o_state.trig[TF_UP] = 1'b1;
        end

        dn       = o_state.trig[TF_DOWN];
        mv       = o_state.trig[TF_MOVE];
        up       = o_state.trig[TF_UP];
        classify = o_state.slot_valid[SV_START]
                 && (o_state.slot_valid[SV_HOLD] || o_state.slot_valid[SV_RELEASE]);

        // Classification.
        if (classify) begin
            priority if (mv && !up) begin
                o_rpt.gesture      = G_MOVETO;
                o_rpt.origin_x     = o_state.start_x;
                o_rpt.origin_y     = o_state.start_y;
                o_rpt.origin_stamp = o_state.start_stamp;
                o_rpt.final_x      = o_state.hold_x;
                o_rpt.final_y      = o_state.hold_y;
                o_rpt.final_stamp  = o_state.hold_stamp;
            end else if (up && !mv && !dn) begin
                o_rpt.gesture        = G_CLICK;
                o_rpt.origin_x       = o_state.start_x;
                o_rpt.origin_y       = o_state.start_y;
                o_rpt.origin_stamp   = o_state.start_stamp;
                o_rpt.final_x        = o_state.rel_x;
                o_rpt.final_y        = o_state.rel_y;
                o_rpt.final_stamp    = o_state.rel_stamp;
                o_state.slot_valid   = '0;
                o_state.trig[TF_UP]  = 1'b0;
            end else if (dn && !up) begin
                o_rpt.gesture      = G_LPUSH;
                o_rpt.origin_x     = o_state.start_x;
                o_rpt.origin_y     = o_state.start_y;
                o_rpt.origin_stamp = o_state.start_stamp;
                o_rpt.final_x      = o_state.hold_x;
                o_rpt.final_y      = o_state.hold_y;
                o_rpt.final_stamp  = o_state.hold_stamp;
            end else begin
            end

            // A release after a move or long push is an overflow. The final
            // stamp comes from the hold slot even when that slot is stale.
            if (up && (mv || dn)) begin
                o_rpt.overflow       = 1'b1;
                o_rpt.gesture        = G_NEITHER;
                o_rpt.origin_x       = o_state.start_x;
                o_rpt.origin_y       = o_state.start_y;
                o_rpt.origin_stamp   = o_state.start_stamp;
                o_rpt.final_x        = o_state.rel_x;
                o_rpt.final_y        = o_state.rel_y;
                o_rpt.final_stamp    = o_state.hold_stamp;
                o_state.slot_valid   = '0;
                o_state.trig[TF_UP]  = 1'b0;
            end
        end else begin
            o_rpt.gesture = G_NEITHER;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/touch_gesture_classifier_core.sv
`default_nettype none
// ============================================================================
// Touch gesture classifier core
// Classifies a stream of touch events into click, move-to and long push.
// ============================================================================
// Every input transaction carries one touch event (none, down, move or up,
// with its position and timestamp) and produces exactly one output
// transaction with the current gesture record. The core sustains one event
// per clock while the output side is ready: an event is captured in the
// input register, then the step logic updates the gesture state and writes
// the report register, which drives the output directly. The result is
// presented once it has passed the input register and the report register;
// a stalled output holds it in the input register. A held-off result blocks
// only the input register behind it, so one more event is taken while a
// result waits. The two configuration registers
// (gesture window and long push time) should be written only while no event
// is in flight; they take effect on the next event. The report holds the
// last complete gesture's points and times; the gesture code reads neither
// while no gesture is complete, and the overflow flag is sticky until the
// gesture window expires.
// ============================================================================
module touch_gesture_classifier_core
    import tgc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [CFG_BITS-1:0]  i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data
);

    logic [CFG_BITS-1:0] r_max_time;
    logic [CFG_BITS-1:0] r_long_time;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;

    t_state    r_state;
    t_state    n_state;
    t_out_item r_rpt;
    t_out_item n_rpt;

    logic      advance;
    logic      fire;

    // The result stage moves when its register is empty or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rpt;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_time  <= MAX_GESTURE_TIME_RST;
            r_long_time <= LONG_PRESS_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_GESTURE_TIME: r_max_time  <= i_cfg_data;
                CFG_LONG_PRESS_TIME:  r_long_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Per-event state update and report.
    tgc_step u_step (
        .i_state     (r_state),
        .i_rpt       (r_rpt),
        .i_item      (r_in),
        .i_max_time  (r_max_time),
        .i_long_time (r_long_time),
        .o_state     (n_state),
        .o_rpt       (n_rpt)
    );

    // Gesture state and report register. The report is visible state, so
    // it resets to a neither record with zero points and times.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_rpt       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_state <= n_state;
                r_rpt   <= n_rpt;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tgc_checker.sv
`default_nettype none
// ============================================================================
// Gesture classifier port checker
// Watches the core's ports for handshake and latency slips.
// ============================================================================
module tgc_checker
    import tgc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_ready,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire t_out_item            o_out_data
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result keeps its transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // With the result register empty, the input side is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result stage");

    // After an accepted event, a valid result is presented at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("accepted event produced no result");

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (.*);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Touch gesture classifier core testbench
// Drives touch event transactions into the core and checks every gesture
// record that comes back against a cycle-free prediction of the core's
// behavior. It starts with a directed event list covering the corner cases of
// the gesture rules and then runs random gesture sequences under several
// window and long push settings, with random idling on both channels.
// ============================================================================
module tb;
    import tgc_pkg::*;

    // Cycles without any accepted transaction before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 2000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_MAX_GESTURE_TIME;
    logic [CFG_BITS-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in_item            in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_item;

    wire in_fire  = in_valid && in_ready;
    wire out_fire = out_valid && out_ready;

    touch_gesture_classifier_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Gesture tracking prediction.
    // The testbench keeps its own copy of the tracking state, the report
    // register and the two configuration registers. It is updated once per
    // accepted input transaction, in acceptance order.
    // ------------------------------------------------------------------------
    t_state               track          = '0;
    t_out_item            gesture_report = '0;
    logic [TIME_BITS-1:0] window_ticks   = MAX_GESTURE_TIME_RST;
    logic [TIME_BITS-1:0] push_ticks     = LONG_PRESS_TIME_RST;

    t_in_item  pending_events[$];
    t_out_item expected_reports[$];

    int unsigned mismatch_count = 0;
    int unsigned report_index   = 0;
    int unsigned queued_count   = 0;
    logic [31:0] clock_now      = '0;
    bit          no_idle        = 1'b0;

    // Copies the gesture origin from the start slot and the given final point
    // into the report register.
    function automatic void fill_report(t_gesture g, logic [COORD_BITS-1:0] fx,
                                        logic [COORD_BITS-1:0] fy,
                                        logic [TIME_BITS-1:0] ft);
        gesture_report.gesture      = g;
        gesture_report.origin_x     = track.start_x;
        gesture_report.origin_y     = track.start_y;
        gesture_report.origin_stamp = track.start_stamp;
        gesture_report.final_x      = fx;
        gesture_report.final_y      = fy;
        gesture_report.final_stamp  = ft;
    endfunction

    function automatic t_out_item classify_touch(t_in_item ev);
        logic [TIME_BITS-1:0] dt;
        logic                 dn, mv, up;
        // Elapsed time since the first down wraps with the timestamp width.
        dt = ev.stamp - track.start_stamp;
        if (!track.slot_valid[SV_START]) begin
            if (ev.event_kind == EV_DOWN) begin
                track.start_x                = ev.pos_x;
                track.start_y                = ev.pos_y;
                track.start_stamp            = ev.stamp;
                track.slot_valid[SV_START]   = 1'b1;
            end
        end else if (dt < window_ticks) begin
            case (ev.event_kind)
                EV_DOWN: begin
                    // A repeated down only counts once it has been held long
                    // enough, and never at zero elapsed time.
                    if (dt >= push_ticks && dt != '0) begin
                        track.hold_x             = ev.pos_x;
                        track.hold_y             = ev.pos_y;
                        track.hold_stamp         = ev.stamp;
                        track.hold_is_down       = 1'b1;
                        track.slot_valid[SV_HOLD] = 1'b1;
                    end
                end
                EV_MOVE: begin
                    track.hold_x              = ev.pos_x;
                    track.hold_y              = ev.pos_y;
                    track.hold_stamp          = ev.stamp;
                    track.hold_is_down        = 1'b0;
                    track.slot_valid[SV_HOLD] = 1'b1;
                end
                EV_UP: begin
                    track.rel_x                  = ev.pos_x;
                    track.rel_y                  = ev.pos_y;
                    track.rel_stamp              = ev.stamp;
                    track.slot_valid[SV_RELEASE] = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            // Window expired: the gesture, overflow flag, triggers and slots are cleared and the event is dropped.
            gesture_report.gesture  = G_NEITHER;
            gesture_report.overflow = 1'b0;
            track.trig              = '0;
            track.slot_valid        = '0;
        end

        if (track.slot_valid[SV_HOLD]) begin
            track.trig[track.hold_is_down ? TF_DOWN : TF_MOVE] = 1'b1;
        end
        if (track.slot_valid[SV_RELEASE]) begin
            track.trig[TF_UP] = 1'b1;
        end

        if (track.slot_valid[SV_START] &&
            (track.slot_valid[SV_HOLD] || track.slot_valid[SV_RELEASE])) begin
            dn = track.trig[TF_DOWN];
            mv = track.trig[TF_MOVE];
            up = track.trig[TF_UP];
            if (mv && !up) begin
                fill_report(G_MOVETO, track.hold_x, track.hold_y, track.hold_stamp);
            end else if (up && !mv && !dn) begin
                fill_report(G_CLICK, track.rel_x, track.rel_y, track.rel_stamp);
                track.slot_valid  = '0;
                track.trig[TF_UP] = 1'b0;
                up                = 1'b0;
            end else if (dn && !up) begin
                fill_report(G_LPUSH, track.hold_x, track.hold_y, track.hold_stamp);
            end
            // A release after a move or long push is an overflow; its final
            // time comes from the hold slot, however old that is.
            if (up && (mv || dn)) begin
                fill_report(G_NEITHER, track.rel_x, track.rel_y, track.hold_stamp);
                gesture_report.overflow = 1'b1;
                track.slot_valid        = '0;
                track.trig[TF_UP]       = 1'b0;
            end
        end else begin
            gesture_report.gesture = G_NEITHER;
        end
        return gesture_report;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued events, one input transaction at a time, with a
    // random gap after each one. The expected record is predicted at the edge
    // where the transaction is accepted.
    // ------------------------------------------------------------------------
    int unsigned in_gap = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (in_fire) begin
                expected_reports.push_back(classify_touch(in_item));
            end
            // A presented event stays put until it is taken.
            if (!in_valid || in_fire) begin
                if (in_gap != 0) begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end else if (pending_events.size() != 0) begin
                    in_item  <= pending_events.pop_front();
                    in_valid <= 1'b1;
                    in_gap   <= no_idle ? 0 : $urandom_range(0, 7);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: after each output transaction it stalls for a random number
    // of cycles. At two points in the run it holds off for a long stretch so
    // that the core backs up and stalls its input side.
    // ------------------------------------------------------------------------
    int unsigned rx_wait  = 0;
    int unsigned rx_count = 0;

    always @(posedge clk) begin : receiver
        int unsigned draw;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
            rx_count  <= 0;
        end else if (out_fire) begin
            draw = no_idle ? 0 : $urandom_range(0, 7);
            if (rx_count + 1 == 100 || rx_count + 1 == 300) begin
                draw = 80;
            end
            rx_count  <= rx_count + 1;
            rx_wait   <= draw;
            out_ready <= (draw == 0);
        end else if (rx_wait != 0) begin
            rx_wait   <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every output transaction is matched against the oldest
    // expected record, one field at a time.
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < 10) begin
                $display("Record %0d, %s: expected %0h, actual %0h",
                         report_index, name, want, got);
            end
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n && out_fire) begin
            if (expected_reports.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("Record %0d arrived with nothing expected: %p",
                             report_index, out_item);
                end
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("gesture",  32'(want.gesture),  32'(out_item.gesture));
                check_field("overflow", 32'(want.overflow), 32'(out_item.overflow));
                check_field("origin_x", 32'(want.origin_x), 32'(out_item.origin_x));
                check_field("origin_y", 32'(want.origin_y), 32'(out_item.origin_y));
                check_field("final_x",  32'(want.final_x),  32'(out_item.final_x));
                check_field("final_y",  32'(want.final_y),  32'(out_item.final_y));
                check_field("origin_stamp", 32'(want.origin_stamp),
                            32'(out_item.origin_stamp));
                check_field("final_stamp",  32'(want.final_stamp),
                            32'(out_item.final_stamp));
            end
            report_index++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run that stops moving for too long has hung.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || in_fire || out_fire || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_point(t_event_kind kind, logic [COORD_BITS-1:0] x,
                             logic [COORD_BITS-1:0] y, logic [TIME_BITS-1:0] ts);
        t_in_item ev;
        ev.event_kind = kind;
        ev.pos_x      = x;
        ev.pos_y      = y;
        ev.stamp      = ts;
        pending_events.push_back(ev);
        queued_count++;
        clock_now = ts;
    endtask

    task automatic add_event(t_event_kind kind, logic [TIME_BITS-1:0] ts);
        add_point(kind, COORD_BITS'($urandom), COORD_BITS'($urandom), ts);
    endtask

    // Uniform pick in [0, limit), or zero when the limit is zero.
    function automatic logic [31:0] draw_below(logic [31:0] limit);
        return (limit == 0) ? 32'd0 : $urandom_range(limit - 1, 0);
    endfunction

    // Random gesture sequences shaped by the current window and long push
    // time. Most are well formed; some time out and some are pure noise.
    task automatic add_gestures(int unsigned count);
        int unsigned          goal, pick;
        logic [TIME_BITS-1:0] base, held;
        goal = queued_count + count;
        while (queued_count < goal) begin
            pick = $urandom_range(0, 9);
            base = ($urandom_range(0, 3) == 0) ? $urandom
                                               : clock_now + $urandom_range(0, 3000);
            if (pick < 8) begin
                add_event(EV_DOWN, base);
            end
            case (pick)
                0, 1, 2: begin
                    // Click, sometimes with an idle event in between.
                    if ($urandom_range(0, 1) == 1) begin
                        add_event(EV_NONE, base + draw_below(window_ticks));
                    end
                    add_event(EV_UP, base + draw_below(window_ticks));
                end
                3, 4: begin
                    // Move-to, usually closed by a release.
                    repeat ($urandom_range(1, 3)) begin
                        add_event(EV_MOVE, base + draw_below(window_ticks));
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        add_event(EV_UP, base + draw_below(window_ticks));
                    end
                end
                5, 6: begin
                    // Long push: a second down held into the valid band.
                    if (window_ticks > push_ticks) begin
                        held = push_ticks + draw_below(window_ticks - push_ticks);
                    end else begin
                        held = draw_below(window_ticks);
                    end
                    add_event(EV_DOWN, base + held);
                    if ($urandom_range(0, 3) != 0) begin
                        add_event(EV_UP, base + held + draw_below(window_ticks - held));
                    end
                end
                7: begin
                    // Any event arriving at or just past the window edge.
                    add_event(t_event_kind'($urandom_range(0, 3)),
                              base + window_ticks + $urandom_range(0, 2));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        add_event(t_event_kind'($urandom_range(0, 3)),
                                  ($urandom_range(0, 1) == 1) ? $urandom
                                      : base + $urandom_range(0, 2000));
                    end
                end
            endcase
        end
    endtask

    // Waits until every queued event has been taken and every expected record
    // has come back, then lets the pipeline settle.
    task automatic wait_idle();
        while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic index, logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == CFG_MAX_GESTURE_TIME) begin
            window_ticks = value;
        end else begin
            push_ticks = value;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_BITS-1:0] window, logic [CFG_BITS-1:0] push,
                             int unsigned count, bit quiet);
        write_reg(CFG_MAX_GESTURE_TIME, window);
        write_reg(CFG_LONG_PRESS_TIME, push);
        no_idle = quiet;
        add_gestures(count);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset window of 1000 and long push of 500.
        add_event(EV_NONE, 32'd0);                        // idle, nothing open
        add_event(EV_UP, 32'd10);                         // release with no gesture
        add_event(EV_MOVE, 32'd20);                       // move with no gesture
        add_point(EV_DOWN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF00);
        add_point(EV_UP, 16'h0000, 16'h0000, 32'h0000_0064);  // click across the wrap
        add_point(EV_DOWN, 16'h0000, 16'hFFFF, 32'd1000);
        add_event(EV_DOWN, 32'd1000);                     // repeated down at zero time
        add_event(EV_DOWN, 32'd1499);                     // one tick short of long push
        add_event(EV_DOWN, 32'd1500);                     // long push exactly at threshold
        add_event(EV_UP, 32'd1600);                       // release after long push
        add_event(EV_DOWN, 32'd2000);
        add_point(EV_MOVE, 16'hFFFF, 16'h0000, 32'd2100); // move-to
        add_event(EV_MOVE, 32'd2200);
        add_event(EV_UP, 32'd2300);                       // release after move
        add_event(EV_DOWN, 32'd3000);
        add_event(EV_NONE, 32'd3999);                     // last tick inside the window
        add_event(EV_NONE, 32'd4000);                     // window expires on an idle event
        add_event(EV_DOWN, 32'd5000);
        add_event(EV_MOVE, 32'd5999);
        add_event(EV_UP, 32'd6000);                       // release exactly at window end
        add_event(EV_DOWN, 32'd7000);
        add_event(EV_UP, 32'd7000);                       // click at zero elapsed time
        wait_idle();

        // Random part over several register settings, extremes included.
        add_gestures(150);
        wait_idle();
        run_phase(32'd0, 32'd0, 30, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 60, 1'b0);
        run_phase(32'd300, 32'd100, 100, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd0, 60, 1'b1);
        run_phase(32'd50, 32'd49, 50, 1'b0);

        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: touch_gesture_classifier_core.f
rtl/core/tgc_pkg.sv
rtl/core/tgc_step.sv
rtl/core/touch_gesture_classifier_core.sv
rtl/core/tgc_checker.sv
sim/tb.sv
